// ----- sv/fpsq_pkg.sv -----
`default_nettype none

package fpsq_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned FracBits  = 16;

   typedef logic [DataWidth-1:0] fpsq_word_type;

   // Q48.16 constants
   localparam fpsq_word_type OneValue     = fpsq_word_type'(65536);
   localparam fpsq_word_type QuarterValue = fpsq_word_type'(16384);
   localparam fpsq_word_type Tolerance    = fpsq_word_type'(10);
   localparam fpsq_word_type ShiftSafeMax = 64'h0000_FFFF_FFFF_FFFF;
   localparam fpsq_word_type AllOnes      = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int unsigned MaxPasses = 8;
   localparam int unsigned PassBits  = $clog2(MaxPasses);

   // divider handshake between sequencer and shared divide unit
   typedef struct packed {
      logic busy;
      logic done;
   } fpsq_div_status_type;

endpackage

`default_nettype wire

// ----- sv/fpsq_channels.sv -----
`default_nettype none

interface fpsq_req_if
   import fpsq_pkg::*;
   ();
   logic          valid;
   logic          ready;
   fpsq_word_type value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface fpsq_rsp_if
   import fpsq_pkg::*;
   ();
   logic          valid;
   logic          ready;
   fpsq_word_type root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

`default_nettype wire

// ----- sv/fpsq_divider.sv -----
`default_nettype none

// radix-2 restoring divider, one quotient bit per cycle
module fpsq_divider
   import fpsq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  fpsq_word_type       dividend,
   input  fpsq_word_type       divisor,
   output fpsq_div_status_type status,
   output fpsq_word_type       quotient
);

   localparam int unsigned CountBits = $clog2(DataWidth);
   localparam logic [CountBits-1:0] LastCount = CountBits'(DataWidth - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CountBits-1:0] count_ff, count_in;
   fpsq_word_type        rem_ff, rem_in;
   fpsq_word_type        quo_ff, quo_in;
   fpsq_word_type        den_ff, den_in;

   logic [DataWidth:0]   shifted;
   logic [DataWidth:0]   trial;

   always_comb begin
      shifted  = {rem_ff, quo_ff[DataWidth-1]};
      trial    = shifted - {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         den_in   = divisor;
      end else if (busy_ff) begin
         if (!trial[DataWidth]) begin
            rem_in = trial[DataWidth-1:0];
            quo_in = {quo_ff[DataWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[DataWidth-1:0];
            quo_in = {quo_ff[DataWidth-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LastCount) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

// ----- sv/fixed_point_square_root.sv -----
`default_nettype none
// a zero or unit operand goes straight to the output state; any other operand runs newton passes
//    (a radix-2 divide plus sequencing each), up to 8 passes
// throughput: one transaction at a time; the shared divider sets the pace
// a saturated or zero-guess quotient skips the divider for that pass
// reset: synchronous, active high; clears the sequencer and the response valid,
//    payload registers keep whatever they held

module fixed_point_square_root
   import fpsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fpsq_req_if.sink   req_if,
   fpsq_rsp_if.source rsp_if
);

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_QUOT   = 6'b000010,
      ST_DIVIDE = 6'b000100,
      ST_STEP   = 6'b001000,
      ST_CHECK  = 6'b010000,
      ST_OUTPUT = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   fpsq_word_type        value_ff, value_in;   // operand of the transaction in flight
   fpsq_word_type        guess_ff, guess_in;   // current newton guess
   fpsq_word_type        quot_ff, quot_in;     // quotient of this pass
   fpsq_word_type        next_ff, next_in;     // candidate next guess
   fpsq_word_type        res_ff, res_in;       // finished result awaiting the output register
   fpsq_word_type        root_ff, root_in;     // response payload register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PassBits-1:0]  pass_ff, pass_in;

   logic                 div_start;
   fpsq_word_type        div_dividend;
   fpsq_div_status_type  div_status;
   fpsq_word_type        div_quotient;
   fpsq_word_type        step_sum;
   fpsq_word_type        step_diff;

   // value << 16 only taken when the operand fits in 48 bits
   assign div_dividend = {value_ff[DataWidth-FracBits-1:0], {FracBits{1'b0}}};
   assign div_start    = (state_ff == ST_QUOT) && (guess_ff != '0)
                         && (value_ff <= ShiftSafeMax);

   fpsq_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (guess_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      guess_in     = guess_ff;
      quot_in      = quot_ff;
      next_in      = next_ff;
      res_in       = res_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff;
      pass_in      = pass_ff;
      // sum wraps modulo 2^64 before halving
      step_sum     = guess_ff + quot_ff;
      step_diff    = (next_ff > guess_ff) ? (next_ff - guess_ff) : (guess_ff - next_ff);

      // response taken downstream
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               value_in = req_if.value;
               pass_in  = '0;
               guess_in = (req_if.value >> 1) + QuarterValue;
               if (req_if.value == '0) begin
                  res_in   = '0;
                  state_in = ST_OUTPUT;
               end else if (req_if.value == OneValue) begin
                  res_in   = OneValue;
                  state_in = ST_OUTPUT;
               end else begin
                  state_in = ST_QUOT;
               end
            end
         end
         ST_QUOT: begin
            // zero guess wins over the overflow check
            if (guess_ff == '0) begin
               quot_in  = '0;
               state_in = ST_STEP;
            end else if (value_ff > ShiftSafeMax) begin
               quot_in  = AllOnes;
               state_in = ST_STEP;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               quot_in  = div_quotient;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            next_in  = step_sum >> 1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (step_diff < Tolerance) begin
               // converged: keep the current guess
               res_in   = guess_ff;
               state_in = ST_OUTPUT;
            end else if (pass_ff == PassBits'(MaxPasses - 1)) begin
               // out of passes: result is the guess after the last update
               res_in   = next_ff;
               state_in = ST_OUTPUT;
            end else begin
               guess_in = next_ff;
               pass_in  = pass_ff + 1'b1;
               state_in = ST_QUOT;
            end
         end
         ST_OUTPUT: begin
            // load the output register once it is free or being emptied
            if (!rsp_valid_ff || rsp_if.ready) begin
               root_in      = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
      end
      value_ff <= value_in;
      guess_ff <= guess_in;
      quot_ff  <= quot_in;
      next_ff  <= next_in;
      res_ff   <= res_in;
      root_ff  <= root_in;
   end

   // ready only while no transaction is in flight
   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.root  = root_ff;

endmodule

`default_nettype wire

// ----- sv/fpsq_checker.sv -----
`default_nettype none

module fpsq_checker
   import fpsq_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input fpsq_word_type rsp_root
);

   // one transaction at a time: no new request right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transaction was in flight");

   // no response right out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_root)))
      else $error("stalled response dropped or changed");

   // an accepted request never produces a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("response appeared too early");

endmodule

bind fixed_point_square_root fpsq_checker u_fpsq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_root  (rsp_if.root)
);

`default_nettype wire
